FILE: hw/rtl/dchr_pkg.sv
// ----------------------------------------------------------------------------
// dchr_pkg
// shared constants for the disc controller host register block
// ----------------------------------------------------------------------------
package dchr_pkg;

  // stream widths
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 48;

  // field widths
  localparam int PORT_W = 2;
  localparam int BYTE_W = 8;
  localparam int WORD_W = 32;
  localparam int IRQ_W  = 5;
  localparam int WIN_W  = 12;

  // buffer sizes
  localparam int PARAM_DEPTH   = 16;
  localparam int RESP_DEPTH    = 16;
  localparam int SECTOR_BYTES  = 4096;
  localparam int SECTOR_BANKS  = 4;
  localparam int SECTOR_ROWS   = (SECTOR_BYTES + SECTOR_BANKS - 1) / SECTOR_BANKS;
  localparam int SEC_RW        = $clog2(SECTOR_ROWS);
  localparam int PARAM_AW      = $clog2(PARAM_DEPTH);
  localparam int PARAM_CW      = $clog2(PARAM_DEPTH + 1);
  localparam int RESP_AW       = $clog2(RESP_DEPTH);
  localparam int RESP_CW       = $clog2(RESP_DEPTH + 1);

  // window geometry
  localparam logic [WIN_W-1:0] WIN_SKIP_WHOLE = 12'd12;
  localparam logic [WIN_W-1:0] WIN_SKIP_DATA  = 12'd24;
  localparam logic [WIN_W-1:0] WIN_LEN_WHOLE  = 12'h924;
  localparam logic [WIN_W-1:0] WIN_LEN_DATA   = 12'h800;

  localparam logic [BYTE_W-1:0] IRQ_READ_FILL = 8'he0;
  localparam int WIN_OPEN_BIT  = 7;
  localparam int PARAM_CLR_BIT = 6;

  // actions
  localparam logic [2:0] ACT_BYTE_RD   = 3'd0;
  localparam logic [2:0] ACT_BYTE_WR   = 3'd1;
  localparam logic [2:0] ACT_WORD_RD   = 3'd2;
  localparam logic [2:0] ACT_RESP_PUSH = 3'd3;
  localparam logic [2:0] ACT_SECTOR_WR = 3'd4;
  localparam logic [2:0] ACT_EVENT     = 3'd5;

  // byte ports
  localparam logic [PORT_W-1:0] PORT_STATUS = 2'd0;
  localparam logic [PORT_W-1:0] PORT_CMD    = 2'd1;
  localparam logic [PORT_W-1:0] PORT_DATA   = 2'd2;
  localparam logic [PORT_W-1:0] PORT_IRQ    = 2'd3;

  // banks
  localparam logic [1:0] BANK_0 = 2'd0;
  localparam logic [1:0] BANK_1 = 2'd1;

  // result source
  localparam logic [1:0] SRC_DIRECT = 2'd0;
  localparam logic [1:0] SRC_RESP   = 2'd1;
  localparam logic [1:0] SRC_PARAM  = 2'd2;
  localparam logic [1:0] SRC_WINDOW = 2'd3;

  typedef struct packed {
    logic [1:0]        src;
    logic [BYTE_W-1:0] direct;
    logic [3:0]        byte_ok;
    logic [1:0]        rot;
    logic [BYTE_W-1:0] cmd;
    logic              strobe;
    logic [IRQ_W-1:0]  irq;
  } res_t;

endpackage

FILE: hw/rtl/dchr_ram.sv
// ----------------------------------------------------------------------------
// dchr_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module dchr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic                                         rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/disc_controller_host_registers.sv
// ----------------------------------------------------------------------------
// disc_controller_host_registers
// banked host byte ports, parameter and response fifos, sector window
// ----------------------------------------------------------------------------
// One input word is taken per clock and its result word appears in the
// output register in the next cycle; a stalled output holds the input off. The
// sector buffer is split into four byte-interleaved ram banks so that a word
// read gets its four bytes from one read port access each in the same cycle.
// No clearing pass after reset: buffers start empty by their counts.
module disc_controller_host_registers (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_data,    // whole_sector
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // port, wdata, sector_addr, raise_flags, busy_in, pop_param
  input  logic [dchr_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [dchr_pkg::IN_USER_W-1:0]  in_tuser,    // action
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // rdata, command_byte, command_strobe, irq_flags
  output logic [dchr_pkg::OUT_DATA_W-1:0] out_tdata
);
  import dchr_pkg::*;

  // input fields
  logic [2:0]        act;
  logic [PORT_W-1:0] port;
  logic [BYTE_W-1:0] wdata;
  logic [WIN_W-1:0]  saddr;
  logic [IRQ_W-1:0]  raise;
  logic              busy_in;
  logic              pop_param;
  logic              in_fire;

  // state
  logic                whole_r;
  logic [1:0]          bank_r, bank_nxt;
  logic [IRQ_W-1:0]    irq_en_r, irq_en_nxt;
  logic [IRQ_W-1:0]    irq_req_r, irq_req_nxt;
  logic                busy_r, busy_nxt;
  logic [PARAM_CW-1:0] p_cnt_r, p_cnt_nxt;
  logic [PARAM_AW-1:0] p_rd_r, p_rd_nxt, p_wr_r, p_wr_nxt;
  logic [RESP_CW-1:0]  r_cnt_r, r_cnt_nxt;
  logic [RESP_AW-1:0]  r_rd_r, r_rd_nxt, r_wr_r, r_wr_nxt;
  logic [WIN_W-1:0]    w_ptr_r, w_ptr_nxt;
  logic [WIN_W-1:0]    w_rem_r, w_rem_nxt;
  logic [BYTE_W-1:0]   cmd_r, cmd_nxt;
  logic                out_valid_r;
  res_t                res_r, res_nxt;

  // working signals
  logic              p_push, r_push, sec_we;
  logic [2:0]        take;
  logic [WIN_W-1:0]  win_pos [4];
  logic [3:0]        in_range;
  logic [BYTE_W-1:0] status;
  logic [BYTE_W-1:0] p_q, r_q;
  logic [BYTE_W-1:0] sec_q [SECTOR_BANKS];
  logic [WORD_W-1:0] rdata;

  assign act       = in_tuser;
  assign port      = in_tdata[1:0];
  assign wdata     = in_tdata[9:2];
  assign saddr     = in_tdata[21:10];
  assign raise     = in_tdata[26:22];
  assign busy_in   = in_tdata[27];
  assign pop_param = in_tdata[28];

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign status = {busy_r, (w_rem_r != '0), (r_cnt_r != '0),
                   (p_cnt_r < PARAM_CW'(PARAM_DEPTH)), (p_cnt_r == '0), 1'b0, bank_r};

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      win_pos[k]  = w_ptr_r + WIN_W'(k);
      in_range[k] = {1'b0, win_pos[k]} < (WIN_W + 1)'(SECTOR_BYTES);
    end
  end

  always_comb begin
    bank_nxt    = bank_r;
    irq_en_nxt  = irq_en_r;
    irq_req_nxt = irq_req_r;
    busy_nxt    = busy_r;
    p_cnt_nxt   = p_cnt_r;
    p_rd_nxt    = p_rd_r;
    p_wr_nxt    = p_wr_r;
    r_cnt_nxt   = r_cnt_r;
    r_rd_nxt    = r_rd_r;
    r_wr_nxt    = r_wr_r;
    w_ptr_nxt   = w_ptr_r;
    w_rem_nxt   = w_rem_r;
    cmd_nxt     = cmd_r;
    p_push      = 1'b0;
    r_push      = 1'b0;
    sec_we      = 1'b0;
    take        = '0;
    res_nxt     = '0;
    res_nxt.src = SRC_DIRECT;
    res_nxt.rot = w_ptr_r[1:0];

    unique case (act)
      ACT_BYTE_RD: begin
        unique case (port)
          PORT_STATUS: res_nxt.direct = status;
          PORT_CMD: begin
            if (r_cnt_r != '0) begin
              res_nxt.src = SRC_RESP;
              r_rd_nxt    = (r_rd_r == RESP_AW'(RESP_DEPTH - 1)) ? '0 : r_rd_r + 1'b1;
              r_cnt_nxt   = r_cnt_r - 1'b1;
            end
          end
          PORT_DATA: begin
            res_nxt.src = SRC_WINDOW;
            take        = (w_rem_r != '0) ? 3'd1 : 3'd0;
          end
          PORT_IRQ: begin
            res_nxt.direct = IRQ_READ_FILL |
                             BYTE_W'(bank_r[0] ? irq_req_r : irq_en_r);
          end
        endcase
      end
      ACT_BYTE_WR: begin
        unique case (port)
          PORT_STATUS: bank_nxt = wdata[1:0];
          PORT_CMD: begin
            if (bank_r == BANK_0) begin
              cmd_nxt        = wdata;
              res_nxt.strobe = 1'b1;
            end
          end
          PORT_DATA: begin
            if (bank_r == BANK_0) begin
              if (p_cnt_r < PARAM_CW'(PARAM_DEPTH)) begin
                p_push    = 1'b1;
                p_wr_nxt  = (p_wr_r == PARAM_AW'(PARAM_DEPTH - 1)) ? '0 : p_wr_r + 1'b1;
                p_cnt_nxt = p_cnt_r + 1'b1;
              end
            end else if (bank_r == BANK_1) begin
              irq_en_nxt = wdata[IRQ_W-1:0];
            end
          end
          PORT_IRQ: begin
            if (bank_r == BANK_0) begin
              w_rem_nxt = '0;
              if (wdata[WIN_OPEN_BIT]) begin
                w_ptr_nxt = whole_r ? WIN_SKIP_WHOLE : WIN_SKIP_DATA;
                w_rem_nxt = whole_r ? WIN_LEN_WHOLE : WIN_LEN_DATA;
              end
            end else if (bank_r == BANK_1) begin
              irq_req_nxt = irq_req_r & ~wdata[IRQ_W-1:0];
              if (wdata[PARAM_CLR_BIT]) begin
                p_cnt_nxt = '0;
                p_rd_nxt  = '0;
                p_wr_nxt  = '0;
              end
            end
          end
        endcase
      end
      ACT_WORD_RD: begin
        res_nxt.src = SRC_WINDOW;
        take        = (w_rem_r >= WIN_W'(4)) ? 3'd4 : w_rem_r[2:0];
      end
      ACT_RESP_PUSH: begin
        if (r_cnt_r < RESP_CW'(RESP_DEPTH)) begin
          r_push    = 1'b1;
          r_wr_nxt  = (r_wr_r == RESP_AW'(RESP_DEPTH - 1)) ? '0 : r_wr_r + 1'b1;
          r_cnt_nxt = r_cnt_r + 1'b1;
        end
      end
      ACT_SECTOR_WR: begin
        sec_we = {1'b0, saddr} < (WIN_W + 1)'(SECTOR_BYTES);
      end
      ACT_EVENT: begin
        irq_req_nxt = irq_req_r | raise;
        busy_nxt    = busy_in;
        if (pop_param && p_cnt_r != '0) begin
          res_nxt.src = SRC_PARAM;
          p_rd_nxt    = (p_rd_r == PARAM_AW'(PARAM_DEPTH - 1)) ? '0 : p_rd_r + 1'b1;
          p_cnt_nxt   = p_cnt_r - 1'b1;
        end
      end
      default: ;
    endcase

    for (int k = 0; k < 4; k++) begin
      res_nxt.byte_ok[k] = (3'(k) < take) && in_range[k];
    end
    w_ptr_nxt = (take != '0) ? w_ptr_r + WIN_W'(take) : w_ptr_nxt;
    w_rem_nxt = (take != '0) ? w_rem_r - WIN_W'(take) : w_rem_nxt;

    res_nxt.cmd = cmd_nxt;
    res_nxt.irq = irq_req_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      whole_r     <= 1'b0;
      bank_r      <= '0;
      irq_en_r    <= '0;
      irq_req_r   <= '0;
      busy_r      <= 1'b0;
      p_cnt_r     <= '0;
      p_rd_r      <= '0;
      p_wr_r      <= '0;
      r_cnt_r     <= '0;
      r_rd_r      <= '0;
      r_wr_r      <= '0;
      w_ptr_r     <= '0;
      w_rem_r     <= '0;
      cmd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        whole_r <= cfg_data;
      end
      if (in_fire) begin
        bank_r    <= bank_nxt;
        irq_en_r  <= irq_en_nxt;
        irq_req_r <= irq_req_nxt;
        busy_r    <= busy_nxt;
        p_cnt_r   <= p_cnt_nxt;
        p_rd_r    <= p_rd_nxt;
        p_wr_r    <= p_wr_nxt;
        r_cnt_r   <= r_cnt_nxt;
        r_rd_r    <= r_rd_nxt;
        r_wr_r    <= r_wr_nxt;
        w_ptr_r   <= w_ptr_nxt;
        w_rem_r   <= w_rem_nxt;
        cmd_r     <= cmd_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  dchr_ram #(.WIDTH(BYTE_W), .DEPTH(PARAM_DEPTH)) u_param_ram (
    .clk     (clk),
    .wr_en   (in_fire && p_push),
    .wr_addr (p_wr_r),
    .wr_data (wdata),
    .rd_en   (in_fire),
    .rd_addr (p_rd_r),
    .rd_data (p_q)
  );

  dchr_ram #(.WIDTH(BYTE_W), .DEPTH(RESP_DEPTH)) u_resp_ram (
    .clk     (clk),
    .wr_en   (in_fire && r_push),
    .wr_addr (r_wr_r),
    .wr_data (wdata),
    .rd_en   (in_fire),
    .rd_addr (r_rd_r),
    .rd_data (r_q)
  );

  // byte-interleaved sector banks
  for (genvar b = 0; b < SECTOR_BANKS; b++) begin : g_sec
    logic [1:0]        kofs;
    logic [SEC_RW-1:0] raddr;

    assign kofs  = 2'(b) - w_ptr_r[1:0];
    assign raddr = win_pos[kofs][2 +: SEC_RW];

    dchr_ram #(.WIDTH(BYTE_W), .DEPTH(SECTOR_ROWS)) u_sec_ram (
      .clk     (clk),
      .wr_en   (in_fire && sec_we && (saddr[1:0] == 2'(b))),
      .wr_addr (saddr[2 +: SEC_RW]),
      .wr_data (wdata),
      .rd_en   (in_fire),
      .rd_addr (raddr),
      .rd_data (sec_q[b])
    );
  end

  always_comb begin
    rdata = '0;
    case (res_r.src)
      SRC_DIRECT: rdata = WORD_W'(res_r.direct);
      SRC_RESP:   rdata = WORD_W'(r_q);
      SRC_PARAM:  rdata = WORD_W'(p_q);
      default: begin
        for (int k = 0; k < 4; k++) begin
          rdata[8*k +: 8] = res_r.byte_ok[k] ? sec_q[res_r.rot + 2'(k)] : '0;
        end
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.irq, res_r.strobe, res_r.cmd, rdata};

endmodule

FILE: sim/dchr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dchr_checker
// watches the host register streams, predicts each result word and compares
// ----------------------------------------------------------------------------
// Keeps its own copy of the bank index, interrupt registers, both fifos, the
// sector buffer and the data window. Every accepted input word queues one
// expected result; every accepted output word is checked field by field
// against the oldest one.
module dchr_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic                            cfg_data,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [dchr_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [dchr_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [dchr_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                              fail_count,
  output int                              pending
);
  import dchr_pkg::*;

  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic [WORD_W-1:0] rdata;
    logic [BYTE_W-1:0] cmd;
    logic              strobe;
    logic [IRQ_W-1:0]  irq;
  } host_result_t;

  logic              whole_sector_q;
  logic [1:0]        bank_q;
  logic [IRQ_W-1:0]  irq_en_q;
  logic [IRQ_W-1:0]  irq_req_q;
  logic              busy_q;
  logic [BYTE_W-1:0] param_fifo[$];
  logic [BYTE_W-1:0] resp_fifo[$];
  logic [BYTE_W-1:0] sector_mem[SECTOR_BYTES];
  logic [WIN_W-1:0]  win_ptr;
  logic [WIN_W-1:0]  win_rem;
  logic [BYTE_W-1:0] last_cmd;
  host_result_t      expected_q[$];

  initial fail_count = 0;

  task automatic report_mismatch(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t dchr_checker: %s got 0x%0h expected 0x%0h", $time, what, got, want);
  endtask

  function automatic logic [BYTE_W-1:0] window_byte();
    logic [BYTE_W-1:0] v;
    v = '0;
    if (win_rem != 0) begin
      v = sector_mem[win_ptr];
      win_ptr = win_ptr + 1'b1;
      win_rem = win_rem - 1'b1;
    end
    return v;
  endfunction

  function automatic logic [BYTE_W-1:0] status_byte();
    return {busy_q, win_rem != 0, resp_fifo.size() != 0, param_fifo.size() < PARAM_DEPTH,
            param_fifo.size() == 0, 1'b0, bank_q};
  endfunction

  function automatic host_result_t predict_access(logic [IN_USER_W-1:0] act,
                                                  logic [IN_DATA_W-1:0] d);
    host_result_t      r;
    logic [PORT_W-1:0] port;
    logic [BYTE_W-1:0] wd;
    logic [WIN_W-1:0]  saddr;
    logic [IRQ_W-1:0]  raise;
    logic              busy_in;
    logic              pop;
    logic [BYTE_W-1:0] b0, b1, b2, b3;
    port    = d[1:0];
    wd      = d[9:2];
    saddr   = d[21:10];
    raise   = d[26:22];
    busy_in = d[27];
    pop     = d[28];
    r = '0;
    case (act)
      ACT_BYTE_RD: begin
        case (port)
          PORT_STATUS: r.rdata = {24'h0, status_byte()};
          PORT_CMD:    if (resp_fifo.size() != 0) r.rdata = {24'h0, resp_fifo.pop_front()};
          PORT_DATA:   r.rdata = {24'h0, window_byte()};
          default:     r.rdata = {24'h0, IRQ_READ_FILL | {3'b000, bank_q[0] ? irq_req_q : irq_en_q}};
        endcase
      end
      ACT_BYTE_WR: begin
        case (port)
          PORT_STATUS: bank_q = wd[1:0];
          PORT_CMD: begin
            if (bank_q == BANK_0) begin
              last_cmd = wd;
              r.strobe = 1'b1;
            end
          end
          PORT_DATA: begin
            if (bank_q == BANK_0) begin
              if (param_fifo.size() < PARAM_DEPTH) param_fifo.push_back(wd);
            end else if (bank_q == BANK_1) begin
              irq_en_q = wd[IRQ_W-1:0];
            end
          end
          default: begin
            if (bank_q == BANK_0) begin
              win_rem = '0;
              if (wd[WIN_OPEN_BIT]) begin
                win_ptr = whole_sector_q ? WIN_SKIP_WHOLE : WIN_SKIP_DATA;
                win_rem = whole_sector_q ? WIN_LEN_WHOLE : WIN_LEN_DATA;
              end
            end else if (bank_q == BANK_1) begin
              irq_req_q = irq_req_q & ~wd[IRQ_W-1:0];
              if (wd[PARAM_CLR_BIT]) param_fifo.delete();
            end
          end
        endcase
      end
      ACT_WORD_RD: begin
        b0 = window_byte();
        b1 = window_byte();
        b2 = window_byte();
        b3 = window_byte();
        r.rdata = {b3, b2, b1, b0};
      end
      ACT_RESP_PUSH: if (resp_fifo.size() < RESP_DEPTH) resp_fifo.push_back(wd);
      ACT_SECTOR_WR: sector_mem[saddr] = wd;
      ACT_EVENT: begin
        irq_req_q = irq_req_q | raise;
        busy_q = busy_in;
        if (pop && param_fifo.size() != 0) r.rdata = {24'h0, param_fifo.pop_front()};
      end
      default: ;
    endcase
    r.cmd = last_cmd;
    r.irq = irq_req_q;
    return r;
  endfunction

  always @(posedge clk) begin
    host_result_t got;
    host_result_t want;
    if (!rst_n) begin
      whole_sector_q = 1'b0;
      bank_q = '0;
      irq_en_q = '0;
      irq_req_q = '0;
      busy_q = 1'b0;
      param_fifo.delete();
      resp_fifo.delete();
      win_ptr = '0;
      win_rem = '0;
      last_cmd = '0;
      expected_q.delete();
      pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) whole_sector_q = cfg_data;
      if (out_tvalid && out_tready) begin
        got.rdata  = out_tdata[31:0];
        got.cmd    = out_tdata[39:32];
        got.strobe = out_tdata[40];
        got.irq    = out_tdata[45:41];
        if (expected_q.size() == 0) begin
          report_mismatch("result word with nothing expected, rdata", got.rdata, '0);
        end else begin
          want = expected_q.pop_front();
          if (got.rdata != want.rdata) report_mismatch("rdata", got.rdata, want.rdata);
          if (got.cmd != want.cmd)
            report_mismatch("command_byte", WORD_W'(got.cmd), WORD_W'(want.cmd));
          if (got.strobe != want.strobe)
            report_mismatch("command_strobe", WORD_W'(got.strobe), WORD_W'(want.strobe));
          if (got.irq != want.irq)
            report_mismatch("irq_flags", WORD_W'(got.irq), WORD_W'(want.irq));
        end
      end
      if (in_tvalid && in_tready) expected_q.push_back(predict_access(in_tuser, in_tdata));
      pending = expected_q.size();
    end
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the disc controller host register block
// ----------------------------------------------------------------------------
// Drives host byte and word accesses, engine events and the sector window
// setting with random idling on both streams; dchr_checker predicts and
// compares every result word. Window reads are only issued on sector bytes
// that were written first.
module tb;
  import dchr_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 780;

  localparam logic [2:0] ACT_SPARE_A = 3'd6;
  localparam logic [2:0] ACT_SPARE_B = 3'd7;
  localparam logic [1:0] BANK_2      = 2'd2;
  localparam logic [1:0] BANK_3      = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic                  cfg_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  int                    fail_count;
  int                    pending;

  int  item_count   = 0;
  int  quiet_cycles = 0;
  bit  no_gaps      = 1'b0;
  bit  hold_request = 1'b0;

  // host-side view, just enough to keep window reads on written bytes
  logic [1:0]       host_bank    = BANK_0;
  bit               host_whole   = 1'b0;
  logic [WIN_W-1:0] host_win_ptr = '0;
  logic [WIN_W-1:0] host_win_rem = '0;
  bit               sector_written[SECTOR_BYTES];

  disc_controller_host_registers u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  dchr_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 4);
    if (r < 9) return $urandom_range(5, 15);
    return $urandom_range(16, 19);
  endfunction

  function automatic logic [IRQ_W-1:0] pick_flags();
    logic [31:0] r;
    r = $urandom;
    if (r[0]) return r[8:4];
    return 5'b00001 << r[11:9];
  endfunction

  // result side
  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        stall = no_gaps ? 0 : pick_gap();
        if (stall == 0) begin
          out_tready = 1'b1;
        end else begin
          out_tready = 1'b0;
          repeat (stall - 1) @(negedge clk);
        end
      end
    end
  end

  task automatic push_item(logic [2:0] act, logic [1:0] port, logic [7:0] wdata,
                           logic [11:0] saddr, logic [4:0] raise, logic busy, logic pop);
    int n;
    int gap;
    n = 0;
    case (act)
      ACT_BYTE_WR: begin
        if (port == PORT_STATUS) begin
          host_bank = wdata[1:0];
        end else if (port == PORT_IRQ && host_bank == BANK_0) begin
          host_win_rem = '0;
          if (wdata[WIN_OPEN_BIT]) begin
            host_win_ptr = host_whole ? WIN_SKIP_WHOLE : WIN_SKIP_DATA;
            host_win_rem = host_whole ? WIN_LEN_WHOLE : WIN_LEN_DATA;
          end
        end
      end
      ACT_SECTOR_WR: sector_written[saddr] = 1'b1;
      ACT_BYTE_RD:   if (port == PORT_DATA) n = 1;
      ACT_WORD_RD:   n = 4;
      default: ;
    endcase
    repeat (n) begin
      if (host_win_rem != 0) begin
        host_win_ptr = host_win_ptr + 1'b1;
        host_win_rem = host_win_rem - 1'b1;
      end
    end
    @(negedge clk);
    in_tuser  = act;
    in_tdata  = {3'b000, pop, busy, raise, saddr, wdata, port};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    item_count++;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // write any unwritten sector byte that the next window read would touch
  task automatic fill_window(int n);
    logic [31:0]      r;
    logic [WIN_W-1:0] addr;
    for (int i = 0; i < n; i++) begin
      if (i < host_win_rem) begin
        addr = host_win_ptr + i[WIN_W-1:0];
        if (!sector_written[addr]) begin
          r = $urandom;
          push_item(ACT_SECTOR_WR, r[1:0], r[9:2], addr, r[14:10], r[15], r[16]);
        end
      end
    end
  endtask

  task automatic issue(logic [2:0] act, logic [1:0] port, logic [7:0] wdata,
                       logic [11:0] saddr, logic [4:0] raise, logic busy, logic pop);
    if (act == ACT_WORD_RD) fill_window(4);
    else if (act == ACT_BYTE_RD && port == PORT_DATA) fill_window(1);
    push_item(act, port, wdata, saddr, raise, busy, pop);
  endtask

  task automatic host_access(logic [2:0] act, logic [1:0] port, logic [7:0] wdata);
    logic [31:0] r;
    r = $urandom;
    issue(act, port, wdata, r[11:0], r[16:12], r[17], r[18]);
  endtask

  task automatic engine_event(logic [4:0] raise, logic busy, logic pop);
    logic [31:0] r;
    r = $urandom;
    issue(ACT_EVENT, r[1:0], r[9:2], r[21:10], raise, busy, pop);
  endtask

  task automatic sector_write(logic [11:0] addr, logic [7:0] data);
    logic [31:0] r;
    r = $urandom;
    issue(ACT_SECTOR_WR, r[1:0], data, addr, r[16:12], r[17], r[18]);
  endtask

  task automatic noise_item();
    logic [31:0] r;
    logic [31:0] f;
    logic [2:0]  act;
    r = $urandom;
    f = $urandom;
    if (r[31:27] == 0) begin
      act = r[26] ? ACT_SPARE_A : ACT_SPARE_B;
    end else begin
      r = $urandom_range(0, 5);
      act = r[2:0];
    end
    issue(act, f[1:0], f[9:2], f[21:10], f[26:22], f[27], f[28]);
  endtask

  task automatic select_bank(logic [1:0] bank);
    logic [31:0] r;
    r = $urandom;
    host_access(ACT_BYTE_WR, PORT_STATUS, {r[5:0], bank});
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_whole_sector(bit v);
    wait_drained();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    host_whole = v;
  endtask

  // host issues a command with parameters, engine consumes and answers
  task automatic command_exchange();
    int          n_par;
    int          n_resp;
    logic [31:0] r;
    n_par  = pick_count();
    n_resp = pick_count();
    select_bank(BANK_0);
    repeat (n_par) host_access(ACT_BYTE_WR, PORT_DATA, 8'($urandom));
    r = $urandom;
    if (r[1:0] == 0) host_access(ACT_BYTE_RD, PORT_STATUS, r[15:8]);
    host_access(ACT_BYTE_WR, PORT_CMD, r[23:16]);
    engine_event('0, 1'b1, 1'b0);
    repeat ($urandom_range(0, n_par + 1)) engine_event(r[2] ? pick_flags() : 5'd0, 1'b1, 1'b1);
    repeat (n_resp) host_access(ACT_RESP_PUSH, r[25:24], 8'($urandom));
    engine_event(pick_flags(), 1'b0, r[3]);
    host_access(ACT_BYTE_RD, PORT_STATUS, r[31:24]);
    repeat ($urandom_range(0, n_resp + 1)) host_access(ACT_BYTE_RD, PORT_CMD, 8'($urandom));
    select_bank(BANK_1);
    host_access(ACT_BYTE_RD, PORT_IRQ, 8'($urandom));
    r = $urandom;
    if (r[2:0] == 0) host_access(ACT_BYTE_WR, PORT_DATA, r[15:8]);
    host_access(ACT_BYTE_WR, PORT_IRQ, {r[23], r[22:20] == 0, r[21:16]});
  endtask

  task automatic window_session();
    int          k;
    logic [31:0] r;
    r = $urandom;
    select_bank(BANK_0);
    if (r[10:8] != 0 || host_win_rem == 0) host_access(ACT_BYTE_WR, PORT_IRQ, r[23:16] | 8'h80);
    else host_access(ACT_BYTE_WR, PORT_IRQ, r[23:16] & 8'h7f);
    repeat ($urandom_range(1, 14)) begin
      k = $urandom_range(0, 9);
      r = $urandom;
      if (k < 4) host_access(ACT_WORD_RD, r[1:0], r[9:2]);
      else if (k < 7) host_access(ACT_BYTE_RD, PORT_DATA, r[9:2]);
      else if (k < 9) sector_write(host_win_ptr + r[2:0], r[15:8]);
      else host_access(ACT_BYTE_RD, PORT_STATUS, r[9:2]);
    end
  endtask

  task automatic random_traffic(int count, bit with_hold);
    int target;
    int k;
    target = item_count + count;
    while (item_count < target) begin
      no_gaps = ($urandom_range(0, 6) == 0);
      if (with_hold && item_count >= target - count / 2) begin
        with_hold = 1'b0;
        @(negedge clk);
        in_tvalid = 1'b0;
        @(posedge clk);
        hold_request = 1'b1;
        no_gaps = 1'b1;
        repeat (30) noise_item();
        no_gaps = 1'b0;
      end
      k = $urandom_range(0, 19);
      if (k < 8) command_exchange();
      else if (k < 13) window_session();
      else repeat ($urandom_range(1, 6)) noise_item();
    end
  endtask

  // read from a fresh window, close it, then read past its end
  task automatic drain_window();
    select_bank(BANK_0);
    host_access(ACT_BYTE_WR, PORT_IRQ, 8'h80 | 8'($urandom));
    host_access(ACT_BYTE_RD, PORT_DATA, 8'($urandom));
    host_access(ACT_WORD_RD, 2'($urandom), 8'($urandom));
    host_access(ACT_BYTE_WR, PORT_IRQ, 8'h7f & 8'($urandom));
    host_access(ACT_WORD_RD, 2'($urandom), 8'($urandom));
    host_access(ACT_BYTE_RD, PORT_DATA, 8'($urandom));
    host_access(ACT_BYTE_RD, PORT_STATUS, 8'($urandom));
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    set_whole_sector(1'b0);

    // reset state, empty fifos, closed window, spare actions
    host_access(ACT_BYTE_RD, PORT_STATUS, 8'h00);
    host_access(ACT_BYTE_RD, PORT_IRQ, 8'hff);
    host_access(ACT_BYTE_RD, PORT_CMD, 8'h00);
    engine_event(5'h00, 1'b0, 1'b1);
    host_access(ACT_BYTE_RD, PORT_DATA, 8'h00);
    host_access(ACT_WORD_RD, PORT_STATUS, 8'hff);
    issue(ACT_SPARE_A, 2'b11, 8'hff, 12'hfff, 5'h1f, 1'b1, 1'b1);
    issue(ACT_SPARE_B, 2'b00, 8'h00, 12'h000, 5'h00, 1'b0, 1'b0);
    // banked writes and interrupt registers
    host_access(ACT_BYTE_WR, PORT_CMD, 8'hff);
    host_access(ACT_BYTE_WR, PORT_STATUS, {6'h3f, BANK_1});
    host_access(ACT_BYTE_WR, PORT_CMD, 8'h5a);
    host_access(ACT_BYTE_WR, PORT_DATA, 8'hff);
    engine_event(5'h1f, 1'b1, 1'b0);
    host_access(ACT_BYTE_RD, PORT_IRQ, 8'h00);
    host_access(ACT_BYTE_RD, PORT_STATUS, 8'h00);
    host_access(ACT_BYTE_WR, PORT_IRQ, 8'hff);
    host_access(ACT_BYTE_WR, PORT_STATUS, {6'h00, BANK_2});
    host_access(ACT_BYTE_WR, PORT_DATA, 8'h33);
    host_access(ACT_BYTE_WR, PORT_IRQ, 8'h80);
    host_access(ACT_BYTE_RD, PORT_IRQ, 8'h00);
    host_access(ACT_BYTE_WR, PORT_STATUS, {6'h00, BANK_3});
    host_access(ACT_BYTE_RD, PORT_IRQ, 8'h00);
    // window open, buffer edges, close
    host_access(ACT_BYTE_WR, PORT_STATUS, {6'h00, BANK_0});
    sector_write(12'hfff, 8'h00);
    sector_write(12'h000, 8'hff);
    host_access(ACT_BYTE_WR, PORT_IRQ, 8'h80);
    host_access(ACT_WORD_RD, PORT_DATA, 8'h00);
    host_access(ACT_BYTE_WR, PORT_IRQ, 8'h7f);
    host_access(ACT_WORD_RD, PORT_DATA, 8'h00);

    set_whole_sector(1'b1);
    random_traffic(RANDOM_ITEMS / 2, 1'b1);
    set_whole_sector(1'b0);
    random_traffic(RANDOM_ITEMS - RANDOM_ITEMS / 2, 1'b0);
    drain_window();
    set_whole_sector(1'b1);
    window_session();
    window_session();

    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
